// ----- hw/rtl/tptlv_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transport parameter decoder package
// Shared types and constants for the front decoder, the record queue and the
// record emitter.
// ----------------------------------------------------------------------------
package tptlv_pkg;

  localparam logic [1:0] KIND_INT  = 2'd0;
  localparam logic [1:0] KIND_RAW  = 2'd1;
  localparam logic [1:0] KIND_FLAG = 2'd2;
  localparam logic [1:0] KIND_END  = 2'd3;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_TRUNC   = 3'd1;
  localparam logic [2:0] ST_ROLE    = 3'd2;
  localparam logic [2:0] ST_BADLEN  = 3'd3;
  localparam logic [2:0] ST_LIMIT   = 3'd4;
  localparam logic [2:0] ST_MISSING = 3'd5;

  localparam logic [4:0] CODE_NONE = 5'd16;

  localparam logic [0:0] CFG_ROLE    = 1'b0;
  localparam logic [0:0] CFG_TIMEOUT = 1'b1;

  typedef enum logic [5:0] {
    PH_TYPE = 6'b000001,
    PH_LEN  = 6'b000010,
    PH_INT  = 6'b000100,
    PH_RAW  = 6'b001000,
    PH_SKIP = 6'b010000,
    PH_ERR  = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [4:0]  code;
    logic [61:0] value;
    logic [11:0] offset;
    logic [2:0]  status;
  } rec_t;

  // One queue entry: the records one input byte causes.
  typedef struct packed {
    logic has_a;
    rec_t rec_a;
    logic has_end;
    logic [2:0] end_status;
    logic [61:0] peer_to;
  } qent_t;

endpackage

// ----- hw/rtl/tptlv_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transport parameter front decoder
// Parses each byte of the parameter block and produces the queue entry that
// describes the records it causes.
// ----------------------------------------------------------------------------
module tptlv_front #(
  parameter int MAX_CID_BYTES = 20,
  parameter int TOKEN_BYTES   = 16,
  parameter int MAX_PARAM_LEN = 4096
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        data_byte,
  input  logic              final_byte,
  input  logic              role_server,
  output tptlv_pkg::qent_t  ent
);

  localparam int PREF_FIXED = 24;
  localparam int LW = $clog2(MAX_PARAM_LEN + 1);

  tptlv_pkg::phase_t phase_r, phase_nxt;
  logic [61:0] acc_r, acc_nxt;
  logic [2:0]  left_r, left_nxt;
  logic [4:0]  param_r, param_nxt;
  logic [LW-1:0] bleft_r, bleft_nxt;
  logic [LW-1:0] vlen_r, vlen_nxt;
  logic [1:0]  pres_r, pres_nxt;
  logic [61:0] peer_r, peer_nxt;
  logic [2:0]  err_r, err_nxt;

  logic        vdone;
  logic [61:0] vacc;
  logic [2:0]  vleft;
  logic [LW-1:0] off;
  logic        is_int;
  logic [3:0]  annc;

  always_comb begin
    if (left_r == 3'd0) begin
      vacc  = {56'd0, data_byte[5:0]};
      case (data_byte[7:6])
        2'd0:    vleft = 3'd0;
        2'd1:    vleft = 3'd1;
        2'd2:    vleft = 3'd3;
        default: vleft = 3'd7;
      endcase
    end else begin
      vacc  = {acc_r[53:0], data_byte};
      vleft = left_r - 3'd1;
    end
    vdone = (vleft == 3'd0);
    case (data_byte[7:6])
      2'd0:    annc = 4'd1;
      2'd1:    annc = 4'd2;
      2'd2:    annc = 4'd4;
      default: annc = 4'd8;
    endcase
    is_int = (param_r == 5'd1) || (param_r >= 5'd3 && param_r <= 5'd11) || (param_r == 5'd14);
    off = vlen_r - bleft_r;
  end

  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    left_nxt  = left_r;
    param_nxt = param_r;
    bleft_nxt = bleft_r;
    vlen_nxt  = vlen_r;
    pres_nxt  = pres_r;
    peer_nxt  = peer_r;
    err_nxt   = err_r;
    ent       = '0;
    case (phase_r)
      tptlv_pkg::PH_TYPE: begin
        acc_nxt  = vacc;
        left_nxt = vleft;
        if (vdone) begin
          param_nxt = (vacc < 62'd16) ? vacc[4:0] : tptlv_pkg::CODE_NONE;
          acc_nxt   = '0;
          phase_nxt = tptlv_pkg::PH_LEN;
        end
      end
      tptlv_pkg::PH_LEN: begin
        acc_nxt  = vacc;
        left_nxt = vleft;
        if (vdone) begin
          bleft_nxt = vacc[LW-1:0];
          vlen_nxt  = vacc[LW-1:0];
          acc_nxt   = '0;
          if (vacc > 62'(MAX_PARAM_LEN)) begin
            err_nxt = tptlv_pkg::ST_BADLEN;
          end else if ((param_r == 5'd0 || param_r == 5'd2 || param_r == 5'd13)
                       && !role_server) begin
            err_nxt = tptlv_pkg::ST_ROLE;
          end else if (param_r == 5'd0 || param_r == 5'd15) begin
            if (vacc > 62'(MAX_CID_BYTES)) begin
              err_nxt = tptlv_pkg::ST_BADLEN;
            end else begin
              pres_nxt = pres_r | ((param_r == 5'd0) ? 2'b01 : 2'b10);
              if (vacc == 62'd0) begin
                ent.has_a      = 1'b1;
                ent.rec_a.kind = tptlv_pkg::KIND_FLAG;
                ent.rec_a.code = param_r;
                phase_nxt      = tptlv_pkg::PH_TYPE;
              end else begin
                phase_nxt = tptlv_pkg::PH_RAW;
              end
            end
          end else if (param_r == 5'd2) begin
            if (vacc != 62'(TOKEN_BYTES)) err_nxt = tptlv_pkg::ST_BADLEN;
            else phase_nxt = tptlv_pkg::PH_RAW;
          end else if (param_r == 5'd13) begin
            if (vacc < 62'(PREF_FIXED + 1 + TOKEN_BYTES) ||
                vacc > 62'(PREF_FIXED + 1 + MAX_CID_BYTES + TOKEN_BYTES))
              err_nxt = tptlv_pkg::ST_BADLEN;
            else phase_nxt = tptlv_pkg::PH_RAW;
          end else if (param_r == 5'd12) begin
            if (vacc != 62'd0) begin
              err_nxt = tptlv_pkg::ST_BADLEN;
            end else begin
              ent.has_a      = 1'b1;
              ent.rec_a.kind = tptlv_pkg::KIND_FLAG;
              ent.rec_a.code = param_r;
              phase_nxt      = tptlv_pkg::PH_TYPE;
            end
          end else if (is_int) begin
            if (vacc == 62'd0 || vacc > 62'd8) err_nxt = tptlv_pkg::ST_BADLEN;
            else phase_nxt = tptlv_pkg::PH_INT;
          end else begin
            phase_nxt = (vacc == 62'd0) ? tptlv_pkg::PH_TYPE : tptlv_pkg::PH_SKIP;
          end
          if (err_nxt != tptlv_pkg::ST_OK) phase_nxt = tptlv_pkg::PH_ERR;
        end
      end
      tptlv_pkg::PH_INT: begin
        if (left_r == 3'd0 && LW'(annc) != bleft_r) begin
          err_nxt   = tptlv_pkg::ST_BADLEN;
          phase_nxt = tptlv_pkg::PH_ERR;
        end else begin
          acc_nxt  = vacc;
          left_nxt = vleft;
          if (vdone) begin
            if (param_r == 5'd10 && vacc > 62'd20) begin
              err_nxt   = tptlv_pkg::ST_LIMIT;
              phase_nxt = tptlv_pkg::PH_ERR;
            end else if (param_r == 5'd11 && vacc >= 62'd16384) begin
              err_nxt   = tptlv_pkg::ST_LIMIT;
              phase_nxt = tptlv_pkg::PH_ERR;
            end else begin
              if (param_r == 5'd1) peer_nxt = vacc;
              ent.has_a       = 1'b1;
              ent.rec_a.kind  = tptlv_pkg::KIND_INT;
              ent.rec_a.code  = param_r;
              ent.rec_a.value = vacc;
              bleft_nxt       = '0;
              phase_nxt       = tptlv_pkg::PH_TYPE;
            end
          end
        end
      end
      tptlv_pkg::PH_RAW: begin
        if (param_r == 5'd13 && off == LW'(PREF_FIXED) &&
            (data_byte > 8'(MAX_CID_BYTES) ||
             vlen_r != LW'(PREF_FIXED + 1 + TOKEN_BYTES) + LW'(data_byte))) begin
          err_nxt   = tptlv_pkg::ST_BADLEN;
          phase_nxt = tptlv_pkg::PH_ERR;
        end else begin
          ent.has_a         = 1'b1;
          ent.rec_a.kind    = tptlv_pkg::KIND_RAW;
          ent.rec_a.code    = param_r;
          ent.rec_a.value   = {54'd0, data_byte};
          ent.rec_a.offset  = 12'(off);
          bleft_nxt         = bleft_r - LW'(1);
          if (bleft_r == LW'(1)) phase_nxt = tptlv_pkg::PH_TYPE;
        end
      end
      tptlv_pkg::PH_SKIP: begin
        bleft_nxt = bleft_r - LW'(1);
        if (bleft_r == LW'(1)) phase_nxt = tptlv_pkg::PH_TYPE;
      end
      default: ;
    endcase

    if (final_byte) begin
      ent.has_end = 1'b1;
      ent.peer_to = peer_nxt;
      if (err_nxt != tptlv_pkg::ST_OK) ent.end_status = err_nxt;
      else if (phase_nxt != tptlv_pkg::PH_TYPE || left_nxt != 3'd0)
        ent.end_status = tptlv_pkg::ST_TRUNC;
      else if ((role_server && !pres_nxt[0]) || !pres_nxt[1])
        ent.end_status = tptlv_pkg::ST_MISSING;
      else ent.end_status = tptlv_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && final_byte)) begin
      phase_r <= tptlv_pkg::PH_TYPE;
      acc_r   <= '0;
      left_r  <= '0;
      param_r <= '0;
      bleft_r <= '0;
      vlen_r  <= '0;
      pres_r  <= '0;
      peer_r  <= '0;
      err_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      left_r  <= left_nxt;
      param_r <= param_nxt;
      bleft_r <= bleft_nxt;
      vlen_r  <= vlen_nxt;
      pres_r  <= pres_nxt;
      peer_r  <= peer_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule

// ----- hw/rtl/tptlv_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transport parameter record queue
// Two-entry queue between the front decoder and the record emitter.
// ----------------------------------------------------------------------------
module tptlv_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  tptlv_pkg::qent_t  push_ent,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output tptlv_pkg::qent_t  head
);

  tptlv_pkg::qent_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign head      = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_ent;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ----- hw/rtl/tptlv_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transport parameter record emitter
// Turns each queue entry into its output transactions (none, one or two) and works
// out the negotiated idle timeout for the end status.
// ----------------------------------------------------------------------------
module tptlv_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              not_empty,
  input  tptlv_pkg::qent_t  head,
  output logic              pop,
  input  logic [61:0]       local_to,
  output logic              out_valid,
  input  logic              out_stall,
  output tptlv_pkg::rec_t   rec,
  output logic              last
);

  logic sent_a_r;
  logic need_a, fire;
  logic [61:0] nego;
  logic [61:0] p;

  assign p      = head.peer_to;
  assign need_a = head.has_a && !sent_a_r;
  assign out_valid = not_empty && (need_a || head.has_end);
  assign fire   = out_valid && !out_stall;
  assign last   = !(need_a && head.has_end);
  assign pop    = not_empty && (!out_valid || (fire && last));

  always_comb begin
    if (p != 62'd0 && local_to != 62'd0) nego = (p < local_to) ? p : local_to;
    else nego = (p > local_to) ? p : local_to;
    if (need_a) begin
      rec = head.rec_a;
    end else begin
      rec        = '0;
      rec.kind   = tptlv_pkg::KIND_END;
      rec.code   = tptlv_pkg::CODE_NONE;
      rec.status = head.end_status;
      rec.value  = (head.end_status == tptlv_pkg::ST_OK) ? nego : 62'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) sent_a_r <= 1'b0;
    else if (pop) sent_a_r <= 1'b0;
    else if (fire) sent_a_r <= 1'b1;
  end

endmodule

// ----- hw/rtl/transport_param_tlv_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transport parameter TLV decoder
// Decodes a transport parameter block one byte per transaction into value,
// raw byte, flag and end status records.
// ----------------------------------------------------------------------------
// The block accepts one byte per clock cycle while in_stall, raised when the
// two-entry queue is full, is low. The front decoder updates the parse state
// for each byte and places its records in the queue; the emitter sends them,
// one record per cycle while out_stall is low, so a byte that yields both a
// record and end status costs two transactions. No clearing pass after reset.
module transport_param_tlv_decoder #(
  parameter int MAX_CID_BYTES = 20,
  parameter int TOKEN_BYTES   = 16,
  parameter int MAX_PARAM_LEN = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_final_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_record_kind,
  output logic [4:0]  out_param_code,
  output logic [61:0] out_value,
  output logic [11:0] out_byte_offset,
  output logic [2:0]  out_status,
  output logic        out_run_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [61:0] cfg_data
);

  logic        role_r;
  logic [61:0] local_r;
  logic        full, not_empty, pop, push;
  tptlv_pkg::qent_t ent, head;
  tptlv_pkg::rec_t  rec;

  assign cfg_ready = 1'b1;
  assign in_stall  = full;
  assign push      = in_valid && !full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      role_r  <= 1'b0;
      local_r <= 62'd30000;
    end else if (cfg_valid) begin
      case (cfg_index)
        tptlv_pkg::CFG_ROLE:    role_r  <= cfg_data[0];
        tptlv_pkg::CFG_TIMEOUT: local_r <= cfg_data;
        default: ;
      endcase
    end
  end

  tptlv_front #(
    .MAX_CID_BYTES(MAX_CID_BYTES),
    .TOKEN_BYTES(TOKEN_BYTES),
    .MAX_PARAM_LEN(MAX_PARAM_LEN)
  ) u_front (
    .clk(clk), .rst_n(rst_n), .step(push), .data_byte(in_data_byte),
    .final_byte(in_final_byte), .role_server(role_r), .ent(ent)
  );

  tptlv_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .push_ent(ent), .full(full),
    .pop(pop), .not_empty(not_empty), .head(head)
  );

  tptlv_back u_back (
    .clk(clk), .rst_n(rst_n), .not_empty(not_empty), .head(head), .pop(pop),
    .local_to(local_r), .out_valid(out_valid), .out_stall(out_stall),
    .rec(rec), .last(out_run_last)
  );

  assign out_record_kind = rec.kind;
  assign out_param_code  = rec.code;
  assign out_value       = rec.value;
  assign out_byte_offset = rec.offset;
  assign out_status      = rec.status;

endmodule

// ----- hw/rtl/tptlv_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transport parameter decoder checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module tptlv_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_record_kind,
  input logic [4:0]  out_param_code,
  input logic [2:0]  out_status,
  input logic [11:0] out_byte_offset,
  input logic        out_run_last
);

  // An end status always closes the records of its byte.
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_record_kind == tptlv_pkg::KIND_END |->
    out_run_last && out_param_code == tptlv_pkg::CODE_NONE)
    else $error("end status not marked last");

  // Only the end status carries a nonzero status.
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_record_kind != tptlv_pkg::KIND_END |-> out_status == tptlv_pkg::ST_OK)
    else $error("status outside end record");

  // A record that is not last is followed by the end status.
  a_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_run_last |=> out_valid &&
    out_record_kind == tptlv_pkg::KIND_END)
    else $error("missing end status after first record");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_record_kind) &&
    $stable(out_byte_offset))
    else $error("stalled result changed");

endmodule

bind transport_param_tlv_decoder tptlv_checker u_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_stall(out_stall),
  .out_record_kind(out_record_kind), .out_param_code(out_param_code),
  .out_status(out_status), .out_byte_offset(out_byte_offset),
  .out_run_last(out_run_last)
);

// ----- bench/tb_transport_param_tlv_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transport parameter TLV decoder testbench
// Sends directed and random parameter blocks one byte per transaction, with
// bursty input and a stalling receiver. A behavioral decoder predicts every
// record, and each received record is compared field by field in order.
// ----------------------------------------------------------------------------
module tb_transport_param_tlv_decoder;

  localparam int LIMIT_CYCLES = 300000;

  typedef struct {
    logic [7:0] b;
    logic       f;
  } byte_item_t;

  typedef struct {
    tptlv_pkg::rec_t r;
    logic last;
  } out_rec_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'd0;
  logic        in_final_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_record_kind;
  logic [4:0]  out_param_code;
  logic [61:0] out_value;
  logic [11:0] out_byte_offset;
  logic [2:0]  out_status;
  logic        out_run_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_index = tptlv_pkg::CFG_ROLE;
  logic [61:0] cfg_data = '0;

  transport_param_tlv_decoder dut (.*);

  always #10 clk = ~clk;

  // Decoder state mirrored for prediction.
  logic        role_server = 1'b0;
  logic [61:0] own_timeout = 62'd30000;
  tptlv_pkg::phase_t ph = tptlv_pkg::PH_TYPE;
  logic [61:0] acc = '0;
  int unsigned vlen_left = 0;
  logic [4:0]  pcode = '0;
  int unsigned remain = 0;
  logic [1:0]  seen = '0;
  logic [61:0] peer_to = '0;
  logic [2:0]  err_code = tptlv_pkg::ST_OK;

  out_rec_t   want_q[$];
  byte_item_t pend_q[$];
  byte_item_t blk[$];

  int n_acc = 0;
  int n_rec = 0;
  int n_blocks = 0;
  int n_err = 0;
  int n_bad_end = 0;
  int gap = 0;
  int burst = 0;
  int cycles = 0;
  int hold_left = 0;
  bit hold_done = 0;
  int stall_mode = 0;

  function automatic void push_rec(logic [1:0] kind, logic [4:0] code, logic [61:0] val,
                                   logic [11:0] off, logic [2:0] st);
    out_rec_t e;
    e.r.kind = kind;
    e.r.code = code;
    e.r.value = val;
    e.r.offset = off;
    e.r.status = st;
    e.last = 1'b0;
    want_q.push_back(e);
  endfunction

  function automatic void latch_err(logic [2:0] st);
    err_code = st;
    ph = tptlv_pkg::PH_ERR;
  endfunction

  function automatic bit is_int_code(logic [4:0] c);
    return c == 1 || (c >= 3 && c <= 11) || c == 14;
  endfunction

  function automatic bit shift_varint(logic [7:0] b);
    if (vlen_left == 0) begin
      acc = {56'd0, b[5:0]};
      vlen_left = (1 << b[7:6]) - 1;
    end else begin
      acc = {acc[53:0], b};
      vlen_left--;
    end
    return vlen_left == 0;
  endfunction

  function automatic void open_value(logic [61:0] len);
    if (len > 4096) begin
      latch_err(tptlv_pkg::ST_BADLEN);
      return;
    end
    if ((pcode == 0 || pcode == 2 || pcode == 13) && !role_server) begin
      latch_err(tptlv_pkg::ST_ROLE);
      return;
    end
    vlen_left = 0;
    acc = len;
    remain = 32'(len);
    if (pcode == 0 || pcode == 15) begin
      if (len > 20) begin
        latch_err(tptlv_pkg::ST_BADLEN);
        return;
      end
      seen = seen | ((pcode == 0) ? 2'b01 : 2'b10);
      if (len == 0) begin
        push_rec(tptlv_pkg::KIND_FLAG, pcode, '0, '0, tptlv_pkg::ST_OK);
        ph = tptlv_pkg::PH_TYPE;
      end else ph = tptlv_pkg::PH_RAW;
    end else if (pcode == 2) begin
      if (len != 16) latch_err(tptlv_pkg::ST_BADLEN);
      else ph = tptlv_pkg::PH_RAW;
    end else if (pcode == 13) begin
      if (len < 41 || len > 61) latch_err(tptlv_pkg::ST_BADLEN);
      else ph = tptlv_pkg::PH_RAW;
    end else if (pcode == 12) begin
      if (len != 0) latch_err(tptlv_pkg::ST_BADLEN);
      else begin
        push_rec(tptlv_pkg::KIND_FLAG, pcode, '0, '0, tptlv_pkg::ST_OK);
        ph = tptlv_pkg::PH_TYPE;
      end
    end else if (is_int_code(pcode)) begin
      if (len == 0 || len > 8) latch_err(tptlv_pkg::ST_BADLEN);
      else ph = tptlv_pkg::PH_INT;
    end else begin
      ph = (len == 0) ? tptlv_pkg::PH_TYPE : tptlv_pkg::PH_SKIP;
    end
  endfunction

  function automatic void predict_byte(logic [7:0] b, logic fin);
    int n0;
    logic [63:0] off;
    logic [2:0] st;
    logic [61:0] val;
    n0 = want_q.size();
    case (ph)
      tptlv_pkg::PH_TYPE: begin
        if (shift_varint(b)) begin
          pcode = (acc < 16) ? acc[4:0] : tptlv_pkg::CODE_NONE;
          acc = '0;
          ph = tptlv_pkg::PH_LEN;
        end
      end
      tptlv_pkg::PH_LEN: begin
        if (shift_varint(b)) open_value(acc);
      end
      tptlv_pkg::PH_INT: begin
        if (vlen_left == 0 && (1 << b[7:6]) != remain) latch_err(tptlv_pkg::ST_BADLEN);
        else if (shift_varint(b)) begin
          if (pcode == 10 && acc > 20) latch_err(tptlv_pkg::ST_LIMIT);
          else if (pcode == 11 && acc >= 16384) latch_err(tptlv_pkg::ST_LIMIT);
          else begin
            if (pcode == 1) peer_to = acc;
            push_rec(tptlv_pkg::KIND_INT, pcode, acc, '0, tptlv_pkg::ST_OK);
            remain = 0;
            ph = tptlv_pkg::PH_TYPE;
          end
        end
      end
      tptlv_pkg::PH_RAW: begin
        off = {2'b00, acc} - remain;
        if (pcode == 13 && off == 24 && (b > 20 || acc != 41 + b))
          latch_err(tptlv_pkg::ST_BADLEN);
        else begin
          push_rec(tptlv_pkg::KIND_RAW, pcode, {54'd0, b}, off[11:0], tptlv_pkg::ST_OK);
          if (remain != 0) remain--;
          if (remain == 0) ph = tptlv_pkg::PH_TYPE;
        end
      end
      tptlv_pkg::PH_SKIP: begin
        if (remain != 0) remain--;
        if (remain == 0) ph = tptlv_pkg::PH_TYPE;
      end
      default: ;
    endcase
    if (fin) begin
      val = '0;
      if (err_code != tptlv_pkg::ST_OK) st = err_code;
      else if (ph != tptlv_pkg::PH_TYPE || vlen_left != 0) st = tptlv_pkg::ST_TRUNC;
      else if ((role_server && !seen[0]) || !seen[1]) st = tptlv_pkg::ST_MISSING;
      else st = tptlv_pkg::ST_OK;
      if (st == tptlv_pkg::ST_OK) begin
        if (peer_to != 0 && own_timeout != 0)
          val = (peer_to < own_timeout) ? peer_to : own_timeout;
        else val = (peer_to > own_timeout) ? peer_to : own_timeout;
      end else n_bad_end++;
      push_rec(tptlv_pkg::KIND_END, tptlv_pkg::CODE_NONE, val, '0, st);
      n_blocks++;
      ph = tptlv_pkg::PH_TYPE;
      acc = '0;
      vlen_left = 0;
      pcode = '0;
      remain = 0;
      seen = '0;
      peer_to = '0;
      err_code = tptlv_pkg::ST_OK;
    end
    if (want_q.size() > n0) want_q[want_q.size() - 1].last = 1'b1;
  endfunction

  // Input driver: bursts with random gaps, payload held while stalled.
  always @(posedge clk) begin
    logic nv;
    byte_item_t it;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      nv = in_valid;
      if (in_valid && !in_stall) begin
        predict_byte(in_data_byte, in_final_byte);
        n_acc++;
        nv = 1'b0;
      end
      if (!nv) begin
        if (gap > 0) begin
          gap--;
        end else if (pend_q.size() > 0) begin
          it = pend_q.pop_front();
          in_data_byte <= it.b;
          in_final_byte <= it.f;
          nv = 1'b1;
          if (burst > 0) burst--;
          else begin
            burst = $urandom_range(1, 24);
            gap = ($urandom % 3 == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
      in_valid <= nv;
    end
  end

  // Receiver stall pattern plus one long hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (hold_left > 0) hold_left--;
      else if (!hold_done && n_acc >= 120) begin
        hold_left = 400;
        hold_done = 1;
      end
      if (cycles % 64 == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
        0: out_stall <= (hold_left > 0);
        1: out_stall <= (hold_left > 0) || ($urandom % 10 < 3);
        default: out_stall <= (hold_left > 0) || ($urandom % 10 < 7);
      endcase
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    out_rec_t e;
    if (rst_n && out_valid && !out_stall) begin
      n_rec++;
      if (want_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("ERROR: unexpected record kind=%0d code=%0d value=%0h",
                                  out_record_kind, out_param_code, out_value);
      end else begin
        e = want_q.pop_front();
        if (out_record_kind !== e.r.kind || out_param_code !== e.r.code ||
            out_value !== e.r.value || out_byte_offset !== e.r.offset ||
            out_status !== e.r.status || out_run_last !== e.last) begin
          n_err++;
          if (n_err <= 10) begin
            $display("ERROR: record %0d expected kind=%0d code=%0d value=%0h off=%0d st=%0d last=%0b",
                     n_rec, e.r.kind, e.r.code, e.r.value, e.r.offset, e.r.status, e.last);
            $display("       actual   kind=%0d code=%0d value=%0h off=%0d st=%0d last=%0b",
                     out_record_kind, out_param_code, out_value, out_byte_offset,
                     out_status, out_run_last);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles with %0d records outstanding", cycles, want_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // Block building helpers.
  function automatic void put_byte(logic [7:0] b);
    byte_item_t it;
    it.b = b;
    it.f = 1'b0;
    blk.push_back(it);
  endfunction

  function automatic void put_varint(logic [63:0] v, int sz);
    logic [7:0] bt;
    for (int k = sz - 1; k >= 0; k--) begin
      bt = 8'(v >> (8 * k));
      if (k == sz - 1) bt[7:6] = (sz == 1) ? 2'd0 : (sz == 2) ? 2'd1 : (sz == 4) ? 2'd2 : 2'd3;
      put_byte(bt);
    end
  endfunction

  function automatic void put_len(int len);
    if (len < 64) put_varint(64'(len), ($urandom % 6 == 0) ? 2 : 1);
    else put_varint(64'(len), 2);
  endfunction

  function automatic void put_bytes(int n);
    for (int i = 0; i < n; i++) put_byte(8'($urandom));
  endfunction

  function automatic void add_cid(int code, int len);
    put_varint(64'(code), 1);
    put_len(len);
    put_bytes(len);
  endfunction

  function automatic void add_int(int code, logic [63:0] v, int sz);
    put_varint(64'(code), 1);
    put_len(sz);
    put_varint(v, sz);
  endfunction

  function automatic void add_pref(int len, int cid_len);
    put_varint(64'd13, 1);
    put_len(len);
    put_bytes(24);
    put_byte(8'(cid_len));
    put_bytes(len - 25);
  endfunction

  function automatic void add_unknown(int len);
    if ($urandom % 4 == 0) put_varint({$urandom, $urandom}, 8);
    else put_varint(64'($urandom_range(16, 63)), 1);
    put_len(len);
    put_bytes(len);
  endfunction

  function automatic void end_block();
    if (blk.size() == 0) put_byte(8'($urandom));
    blk[blk.size() - 1].f = 1'b1;
    foreach (blk[i]) pend_q.push_back(blk[i]);
    blk.delete();
  endfunction

  function automatic void add_rand_entry();
    int int_codes[11] = '{1, 3, 4, 5, 6, 7, 8, 9, 10, 11, 14};
    int code;
    int sz;
    int cl;
    logic [63:0] t;
    case ($urandom % 8)
      0, 1, 2, 3: begin
        code = int_codes[$urandom % 11];
        sz = 1 << $urandom_range(0, 3);
        t = {$urandom, $urandom};
        t = t >> (64 - (8 * sz - 2));
        if (code == 10) t = 64'($urandom_range(0, 23));
        if (code == 11) begin
          sz = 4;
          t = 64'($urandom_range(16300, 16450));
        end
        add_int(code, t, sz);
      end
      4: add_cid(($urandom % 4 == 0) ? 0 : 15, $urandom_range(0, 20));
      5: begin
        if ($urandom % 2) add_cid(2, 16);
        else begin
          cl = $urandom_range(0, 20);
          add_pref(41 + cl, cl);
        end
      end
      6: add_cid(12, 0);
      default: add_unknown($urandom_range(0, 8));
    endcase
  endfunction

  function automatic void rand_block();
    int n;
    int pos;
    int c;
    if ($urandom % 10 == 0) begin
      put_bytes($urandom_range(1, 24));
      end_block();
      return;
    end
    n = $urandom_range(0, 5);
    pos = $urandom_range(0, n);
    for (int i = 0; i <= n; i++) begin
      if (i == pos) begin
        if (role_server || $urandom % 8 == 0) add_cid(0, $urandom_range(0, 20));
        add_cid(15, $urandom_range(0, 20));
      end
      if (i < n) begin
        if (!role_server && $urandom % 3 != 0) add_int(4, 64'($urandom_range(0, 63)), 1);
        else add_rand_entry();
      end
    end
    c = $urandom % 100;
    if (c < 8) blk[$urandom % blk.size()].b = 8'($urandom);
    else if (c < 14 && blk.size() > 1) begin
      pos = $urandom_range(1, blk.size() - 1);
      while (blk.size() > pos) void'(blk.pop_back());
    end
    end_block();
  endfunction

  task automatic wait_idle();
    while (pend_q.size() != 0 || in_valid || want_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_cfg(logic [0:0] idx, logic [61:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == tptlv_pkg::CFG_ROLE) role_server = data[0];
    else own_timeout = data;
  endtask

  task automatic run_phase(bit role, logic [61:0] tmo, int target);
    int start;
    wait_idle();
    write_cfg(tptlv_pkg::CFG_ROLE, {61'd0, role});
    write_cfg(tptlv_pkg::CFG_TIMEOUT, tmo);
    @(posedge clk);
    start = pend_q.size();
    while (pend_q.size() - start < target) rand_block();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Default configuration: minimal block, every integer entry, errors.
    add_cid(15, 0);
    end_block();
    add_int(1, 64'h3FFF_FFFF_FFFF_FFFF, 8);
    add_int(3, 64'd0, 1);
    add_int(4, 64'd63, 1);
    add_int(5, 64'd16383, 2);
    add_int(6, 64'h3FFF_FFFF, 4);
    for (int c = 7; c <= 9; c++) add_int(c, 64'($urandom_range(0, 63)), 1);
    add_int(10, 64'd20, 1);
    add_int(11, 64'd16383, 4);
    add_int(14, 64'd1, 8);
    add_cid(12, 0);
    add_unknown(0);
    add_cid(15, 20);
    end_block();
    add_cid(0, 4);
    end_block();
    add_int(10, 64'd21, 1);
    end_block();
    add_cid(15, 5);
    void'(blk.pop_back());
    void'(blk.pop_back());
    end_block();
    add_int(3, 64'd5, 1);
    end_block();
    run_phase(1'b0, 62'd30000, 40);

    // Server role with no local timeout: server-only entries, length and limit errors.
    run_phase(1'b1, 62'd0, 0);
    add_cid(0, 0);
    add_cid(15, 3);
    add_cid(2, 16);
    add_pref(61, 20);
    end_block();
    add_cid(2, 15);
    end_block();
    add_cid(15, 21);
    end_block();
    add_int(4, 64'd0, 1);
    blk[1].b = 8'd9;
    end_block();
    add_int(11, 64'd16384, 4);
    end_block();
    add_cid(12, 1);
    end_block();
    put_varint(64'd20, 1);
    put_varint(64'd4097, 2);
    end_block();
    add_pref(45, 3);
    end_block();
    add_int(7, 64'd0, 4);
    blk[2].b = 8'h00;
    end_block();
    while (pend_q.size() < 200) rand_block();

    run_phase(1'b1, 62'h3FFF_FFFF_FFFF_FFFF, 30);
    run_phase(1'b0, 62'({$urandom, $urandom}), 30);
    run_phase(1'b1, 62'($urandom_range(1, 100000)), 20);

    wait_idle();
    repeat (20) @(posedge clk);
    $display("Checked %0d records from %0d bytes in %0d blocks (%0d ended in error).",
             n_rec, n_acc, n_blocks, n_bad_end);
    if (n_err == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Mismatches: %0d", n_err);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
